[hw/rtl/pbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse beat detector package
// Shared constants, register indexes and enumerated types.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // Default parameter values
  localparam int unsigned HISTORY_DEPTH_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF   = 10;

  // Fixed field widths
  localparam int unsigned ELAPSED_W   = 12;
  localparam int unsigned TICK_W      = 4;
  localparam int unsigned SEED_W      = 10;
  localparam int unsigned RATE_W      = 8;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned CFG_INDEX_W = 2;

  // Width of the shared divider; holds the scaled rate numerator (q * 5)
  localparam int unsigned DIV_W = 19;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Arithmetic constants of the rate formula and the beat gate
  localparam logic [DIV_W-1:0] BPM_NUMER   = DIV_W'(60000);
  localparam logic [DIV_W-1:0] RATE_DIVISOR = DIV_W'(14);
  localparam logic [DIV_W-1:0] GATE_DIVISOR = DIV_W'(5);
  localparam logic [RATE_W-1:0] RATE_MAX   = '1;

  // Reset values
  localparam logic [TICK_W-1:0]    TICK_RST     = TICK_W'(2);
  localparam logic [ELAPSED_W-1:0] REFR_RST     = ELAPSED_W'(250);
  localparam logic [ELAPSED_W-1:0] TIMEOUT_RST  = ELAPSED_W'(2500);
  localparam logic [SEED_W-1:0]    SEED_RST     = SEED_W'(512);
  localparam logic [ELAPSED_W-1:0] INTERVAL_RST = ELAPSED_W'(600);
  localparam int unsigned          LEVEL_RST    = 512;
  localparam int unsigned          AMP_RST      = 100;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TICK       = 2'd0,
    CFG_REFRACTORY = 2'd1,
    CFG_TIMEOUT    = 2'd2,
    CFG_SEED       = 2'd3
  } cfg_reg_e;

  // Interval history operations
  typedef enum logic [1:0] {
    HIST_HOLD,
    HIST_FILL,
    HIST_PUSH,
    HIST_ROTATE
  } hist_op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATE_DIV,
    ST_EVAL,
    ST_SUM,
    ST_AVG_DIV,
    ST_BPM_DIV,
    ST_SCALE,
    ST_RATE_DIV,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

[hw/rtl/pbd_serial_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse beat detector serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbd_serial_div #(
  parameter int unsigned Width = pbd_pkg::DIV_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  done_o,
  output logic [Width-1:0]      quotient_o
);
  import pbd_pkg::*;

  localparam int unsigned CntW = $clog2(Width);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] dvs_q;
  logic [Width:0]   trial, diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[Width-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? diff[Width-1:0] : trial[Width-1:0];
    quo_d = {quo_q[Width-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Width - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_nonzero_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0) else $error("divide by zero requested");
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_q) && !busy_q)) else $error("spurious divider done");

endmodule
`default_nettype wire

[hw/rtl/pbd_history.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse beat detector interval history
// Shift line of beat intervals; read at the oldest entry, rotated to sum.
// ----------------------------------------------------------------------------
module pbd_history #(
  parameter int unsigned Depth = pbd_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned Width = pbd_pkg::ELAPSED_W
) (
  input  wire logic             clk_i,
  input  wire pbd_pkg::hist_op_e op_i,
  input  wire logic [Width-1:0] wr_data_i,
  output logic [Width-1:0]      rd_data_o
);
  import pbd_pkg::*;

  logic [Width-1:0] hist_q [Depth];

  // Entries carry no reset: the first write is always a fill.
  always_ff @(posedge clk_i) begin
    case (op_i)
      HIST_FILL: begin
        for (int k = 0; k < Depth; k++) hist_q[k] <= wr_data_i;
      end
      HIST_PUSH: begin
        for (int k = 0; k < Depth - 1; k++) hist_q[k] <= hist_q[k+1];
        hist_q[Depth-1] <= wr_data_i;
      end
      HIST_ROTATE: begin
        for (int k = 0; k < Depth - 1; k++) hist_q[k] <= hist_q[k+1];
        hist_q[Depth-1] <= hist_q[0];
      end
      default: ;
    endcase
  end

  assign rd_data_o = hist_q[0];

endmodule
`default_nettype wire

[hw/rtl/pulse_beat_detector_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse beat detector
// Peak, trough and adaptive-threshold beat detection on pulse samples,
// with a rate taken from the average of the recent beat intervals.
// ----------------------------------------------------------------------------
// Processing: a taken sample passes the gate division and the evaluation; a counted
//   beat adds the history summation and the average, BPM and rate divisions; the serial
//   divider (one bit a cycle) and the history summation (one entry a cycle) set the time.
// Throughput: one sample at a time; the next is taken in the cycle after the result
//   item is registered, later while the result side stalls.
// Reset: asynchronous, active low; the interval history and payload registers do not reset.
// ----------------------------------------------------------------------------
module pulse_beat_detector_unit #(
  parameter int unsigned HISTORY_DEPTH = pbd_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = pbd_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned InTdataW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OutFieldW = 2 + pbd_pkg::RATE_W + pbd_pkg::ELAPSED_W + SAMPLE_BITS,
  localparam int unsigned OutTdataW = ((OutFieldW + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [pbd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [pbd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Sample stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: sample (SAMPLE_BITS), zero padding
  input  wire logic [InTdataW-1:0]             s_axis_tdata_i,
  // Result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // tdata: pulse_high (1), beat_found (1), beats_per_minute (8),
  //        beat_interval (12), amplitude (SAMPLE_BITS), zero padding
  output logic [OutTdataW-1:0]                 m_axis_tdata_o
);
  import pbd_pkg::*;

  localparam int unsigned Lvl    = SAMPLE_BITS;
  localparam int unsigned CntW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned SumW   = ELAPSED_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned SeedXW = SAMPLE_BITS + SEED_W;
  localparam logic [Lvl-1:0] LvlRst = Lvl'(LEVEL_RST);
  localparam logic [Lvl-1:0] AmpRst = Lvl'(AMP_RST);

  // Configuration registers
  logic [TICK_W-1:0]    tick_q;
  logic [ELAPSED_W-1:0] refr_q, timeout_q;
  logic [SEED_W-1:0]    seed_q;

  // Detector state
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d, last_int_q, last_int_d;
  logic                 above_q, above_d, first_q, first_d, second_q, second_d;
  logic [Lvl-1:0]       peak_q, peak_d, trough_q, trough_d, thr_q, thr_d;
  logic [Lvl-1:0]       amp_q, amp_d;
  logic [RATE_W-1:0]    rate_q;

  // Per-item working registers
  state_e               state_q, state_d;
  logic [Lvl-1:0]       smp_q;
  logic [ELAPSED_W-1:0] num_q;
  logic                 found_q, found_d;
  logic [SumW-1:0]      sum_q, sum_d;
  logic [CntW-1:0]      cnt_q;
  logic [DIV_W-1:0]     prod_q;

  // Result register
  logic                 m_valid_q;
  logic [OutTdataW-1:0] m_data_q;

  // Shared divider and history
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dvd, div_dvs, div_quo;
  hist_op_e         hist_op;
  logic [ELAPSED_W-1:0] hist_rd;

  pbd_serial_div #(.Width(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  pbd_history #(.Depth(HISTORY_DEPTH), .Width(ELAPSED_W)) u_hist (
    .clk_i     (clk_i),
    .op_i      (hist_op),
    .wr_data_i (num_q),
    .rd_data_o (hist_rd)
  );

  // Elapsed time advanced by one tick, saturating.
  logic [ELAPSED_W:0] elapsed_sum;
  logic [ELAPSED_W-1:0] num_next;
  always_comb begin
    elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(tick_q);
    num_next    = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
  end

  // Seed level fitted to the sample width.
  logic [SeedXW-1:0] seed_ext;
  logic [Lvl-1:0]    seed_lvl;
  assign seed_ext = SeedXW'(seed_q);
  assign seed_lvl = seed_ext[Lvl-1:0];

  // Tick evaluation. The divider still holds last_interval / 5 here, and
  // every test uses the threshold and elapsed count from the start of the
  // tick, as the update order requires.
  logic [ELAPSED_W-1:0] gate_quo;
  logic [ELAPSED_W:0]   gate;
  logic                 s_lt_thr, s_gt_thr, past_gate, beat, skip_rest;
  logic [Lvl-1:0]       peak_1, trough_1, amp_fall;
  logic [Lvl:0]         thr_sum;
  hist_op_e             eval_op;

  always_comb begin
    gate_quo  = div_quo[ELAPSED_W-1:0];
    gate      = {1'b0, gate_quo} + {gate_quo, 1'b0};
    s_lt_thr  = smp_q < thr_q;
    s_gt_thr  = smp_q > thr_q;
    past_gate = {1'b0, num_q} > gate;

    trough_1 = (s_lt_thr && past_gate && (smp_q < trough_q)) ? smp_q : trough_q;
    peak_1   = (s_gt_thr && (smp_q > peak_q)) ? smp_q : peak_q;

    beat      = (num_q > refr_q) && s_gt_thr && !above_q && past_gate;
    skip_rest = beat && first_q;
    found_d   = beat && !first_q;

    above_d    = above_q;
    last_int_d = last_int_q;
    elapsed_d  = num_q;
    first_d    = first_q;
    second_d   = second_q;
    peak_d     = peak_1;
    trough_d   = trough_1;
    thr_d      = thr_q;
    amp_d      = amp_q;
    eval_op    = HIST_HOLD;

    if (beat) begin
      above_d    = 1'b1;
      last_int_d = num_q;
      elapsed_d  = '0;
      second_d   = 1'b0;
      // On the second beat the whole history takes this interval.
      if (second_q)      eval_op = HIST_FILL;
      else if (!first_q) eval_op = HIST_PUSH;
      if (first_q) begin
        first_d  = 1'b0;
        second_d = 1'b1;
      end
    end

    amp_fall = (peak_1 >= trough_1) ? (peak_1 - trough_1) : '0;
    thr_sum  = {1'b0, amp_fall >> 1} + {1'b0, trough_1};

    if (!skip_rest) begin
      // Falling edge: new threshold halfway up the last swing.
      if (s_lt_thr && above_d) begin
        above_d  = 1'b0;
        amp_d    = amp_fall;
        thr_d    = thr_sum[Lvl-1:0];
        peak_d   = thr_sum[Lvl-1:0];
        trough_d = thr_sum[Lvl-1:0];
      end
      // Silence timeout: back to the seed levels, wait for a first beat.
      if (num_q > timeout_q) begin
        thr_d     = seed_lvl;
        peak_d    = seed_lvl;
        trough_d  = seed_lvl;
        elapsed_d = '0;
        first_d   = 1'b1;
        second_d  = 1'b0;
      end
    end
  end

  // Sequencer: next state, divider operands and history operation.
  logic [DIV_W-1:0] avg_full;
  assign sum_d    = sum_q + SumW'(hist_rd);
  assign avg_full = div_quo;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = GATE_DIVISOR;
    hist_op   = HIST_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(last_int_q);
          div_dvs   = GATE_DIVISOR;
          state_d   = ST_GATE_DIV;
        end
      end
      ST_GATE_DIV: begin
        if (div_done) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        hist_op = eval_op;
        state_d = found_d ? ST_SUM : ST_OUT;
      end
      ST_SUM: begin
        hist_op = HIST_ROTATE;
        if (cnt_q == CntW'(HISTORY_DEPTH - 1)) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(sum_d);
          div_dvs   = DIV_W'(HISTORY_DEPTH);
          state_d   = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: begin
        if (div_done) begin
          if (avg_full == '0) begin
            state_d = ST_OUT;
          end else begin
            div_start = 1'b1;
            div_dvd   = BPM_NUMER;
            div_dvs   = avg_full;
            state_d   = ST_BPM_DIV;
          end
        end
      end
      ST_BPM_DIV: begin
        if (div_done) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        div_start = 1'b1;
        div_dvd   = prod_q;
        div_dvs   = RATE_DIVISOR;
        state_d   = ST_RATE_DIV;
      end
      ST_RATE_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Control and detector state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tick_q     <= TICK_RST;
      refr_q     <= REFR_RST;
      timeout_q  <= TIMEOUT_RST;
      seed_q     <= SEED_RST;
      elapsed_q  <= '0;
      last_int_q <= INTERVAL_RST;
      above_q    <= 1'b0;
      peak_q     <= LvlRst;
      trough_q   <= LvlRst;
      thr_q      <= LvlRst;
      amp_q      <= AmpRst;
      first_q    <= 1'b1;
      second_q   <= 1'b0;
      rate_q     <= '0;
      found_q    <= 1'b0;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_TICK:       tick_q    <= cfg_data_i[TICK_W-1:0];
          CFG_REFRACTORY: refr_q    <= cfg_data_i[ELAPSED_W-1:0];
          CFG_TIMEOUT:    timeout_q <= cfg_data_i[ELAPSED_W-1:0];
          CFG_SEED:       seed_q    <= cfg_data_i[SEED_W-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_EVAL) begin
        elapsed_q  <= elapsed_d;
        last_int_q <= last_int_d;
        above_q    <= above_d;
        peak_q     <= peak_d;
        trough_q   <= trough_d;
        thr_q      <= thr_d;
        amp_q      <= amp_d;
        first_q    <= first_d;
        second_q   <= second_d;
        found_q    <= found_d;
        cnt_q      <= '0;
      end

      if (state_q == ST_SUM) cnt_q <= cnt_q + 1'b1;

      // A zero average saturates the rate.
      if (state_q == ST_AVG_DIV && div_done && avg_full == '0) rate_q <= RATE_MAX;
      if (state_q == ST_RATE_DIV && div_done) begin
        rate_q <= (div_quo > DIV_W'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_W-1:0];
      end

      if (state_q == ST_OUT && (!m_valid_q || m_axis_tready_i)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      smp_q <= s_axis_tdata_i[Lvl-1:0];
      num_q <= num_next;
    end
    if (state_q == ST_EVAL) sum_q <= '0;
    if (state_q == ST_SUM)  sum_q <= sum_d;
    // Rate numerator q * 5 as q * 4 + q.
    if (state_q == ST_BPM_DIV && div_done) prod_q <= (div_quo << 2) + div_quo;
    if (state_q == ST_OUT && (!m_valid_q || m_axis_tready_i)) begin
      m_data_q <= OutTdataW'({amp_q, last_int_q, rate_q, found_q, above_q});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_sum_only_on_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> found_q) else $error("rate work without a counted beat");
  a_beat_means_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_data_q[1]) |-> m_data_q[0])
    else $error("counted beat reported without pulse high");
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second item taken during evaluation");
  a_eval_after_gate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> $past(div_done)) else $error("evaluation before gate ready");

endmodule
`default_nettype wire
